// ===== hdl/sfp7_pkg.sv =====
// ----------------------------------------------------------------------------
// sfp7_pkg
// shared types, constants and segment table for the signed fixed point to
// seven segment encoder
// ----------------------------------------------------------------------------
package sfp7_pkg;

  localparam int VALUE_W  = 21;
  localparam int DIGITS   = 6;
  localparam int SEG_W    = 8;
  localparam int HI_W     = 11;
  localparam int LO_W     = 10;
  localparam int REM_W    = 7;
  localparam int BCD_W    = 4;

  // floor(x / 1000) = (x * RECIP_1000) >> Q_SHIFT for x < 2**21
  localparam int unsigned RECIP_1000 = 32'd8589935;
  localparam int          Q_SHIFT    = 33;
  localparam int          PROD_W     = 45;

  // floor(x / 100) for x < 1099 and floor(x / 10) for x < 100
  localparam int unsigned RECIP_100  = 32'd41;
  localparam int          H_SHIFT    = 12;
  localparam int unsigned RECIP_10   = 32'd205;
  localparam int          T_SHIFT    = 11;

  localparam logic [SEG_W-1:0] SEG_BLANK   = 8'hFF;
  localparam logic [SEG_W-1:0] SEG_MINUS   = 8'hBF;
  localparam logic [SEG_W-1:0] SEG_DP_MASK = 8'h7F;

  localparam logic [SEG_W-1:0] ERR_SEG0 = 8'hAF;
  localparam logic [SEG_W-1:0] ERR_SEG1 = 8'hA3;
  localparam logic [SEG_W-1:0] ERR_SEG2 = 8'hAF;
  localparam logic [SEG_W-1:0] ERR_SEG3 = 8'hAF;
  localparam logic [SEG_W-1:0] ERR_SEG4 = 8'h86;
  localparam logic [SEG_W-1:0] ERR_SEG5 = 8'hFF;

  localparam logic OP_NUMBER = 1'b0;
  localparam logic OP_ERROR  = 1'b1;

  typedef struct packed {
    logic            op;
    logic            neg;
    logic [HI_W-1:0] hi;
    logic [LO_W-1:0] lo;
  } split_t;

  typedef struct packed {
    logic                         op;
    logic                         neg;
    logic [DIGITS-1:0][BCD_W-1:0] dig;
  } digits_t;

  function automatic logic [SEG_W-1:0] seg_digit(input logic [BCD_W-1:0] d);
    logic [SEG_W-1:0] s;
    unique case (d)
      4'd0:    s = 8'hC0;
      4'd1:    s = 8'hF9;
      4'd2:    s = 8'hA4;
      4'd3:    s = 8'hB0;
      4'd4:    s = 8'h99;
      4'd5:    s = 8'h92;
      4'd6:    s = 8'h82;
      4'd7:    s = 8'hF8;
      4'd8:    s = 8'h80;
      4'd9:    s = 8'h90;
      default: s = SEG_BLANK;
    endcase
    return s;
  endfunction

endpackage

// ===== hdl/sfp7_split.sv =====
// ----------------------------------------------------------------------------
// sfp7_split
// input register, magnitude, and split of the magnitude into thousands and
// the remainder below one thousand
// ----------------------------------------------------------------------------
module sfp7_split (
  input  logic                         clk,
  input  logic                         en,
  input  logic                         op,
  input  logic [sfp7_pkg::VALUE_W-1:0] value,
  output sfp7_pkg::split_t             split
);

  logic                         op1;
  logic [sfp7_pkg::VALUE_W-1:0] val1;
  logic                         op2;
  logic                         neg2;
  logic [sfp7_pkg::VALUE_W-1:0] mag2;
  logic [sfp7_pkg::HI_W-1:0]    q2;

  logic                         neg;
  logic [sfp7_pkg::VALUE_W-1:0] mag;
  logic [sfp7_pkg::PROD_W-1:0]  prod;
  logic [sfp7_pkg::VALUE_W-1:0] lo_full;

  assign neg  = val1[sfp7_pkg::VALUE_W-1];
  assign mag  = neg ? (~val1 + sfp7_pkg::VALUE_W'(1)) : val1;
  assign prod = sfp7_pkg::PROD_W'(mag) * sfp7_pkg::PROD_W'(sfp7_pkg::RECIP_1000);

  assign lo_full = mag2 - sfp7_pkg::VALUE_W'(q2) * sfp7_pkg::VALUE_W'(1000);

  always_ff @(posedge clk) begin
    if (en) begin
      op1        <= op;
      val1       <= value;
      op2        <= op1;
      neg2       <= neg;
      mag2       <= mag;
      q2         <= prod[sfp7_pkg::Q_SHIFT +: sfp7_pkg::HI_W];
      split.op   <= op2;
      split.neg  <= neg2;
      split.hi   <= q2;
      split.lo   <= lo_full[sfp7_pkg::LO_W-1:0];
    end
  end

endmodule

// ===== hdl/sfp7_digits.sv =====
// ----------------------------------------------------------------------------
// sfp7_digits
// splits the thousands and the remainder into three decimal digits each
// ----------------------------------------------------------------------------
module sfp7_digits (
  input  logic              clk,
  input  logic              en,
  input  sfp7_pkg::split_t  split,
  output sfp7_pkg::digits_t digits
);

  logic                       op4;
  logic                       neg4;
  logic [sfp7_pkg::BCD_W-1:0] h_hi;
  logic [sfp7_pkg::BCD_W-1:0] h_lo;
  logic [sfp7_pkg::REM_W-1:0] r_hi;
  logic [sfp7_pkg::REM_W-1:0] r_lo;

  logic [15:0]                p_hi;
  logic [15:0]                p_lo;
  logic [sfp7_pkg::BCD_W-1:0] hh;
  logic [sfp7_pkg::BCD_W-1:0] hl;
  logic [sfp7_pkg::HI_W-1:0]  rem_hi;
  logic [sfp7_pkg::HI_W-1:0]  rem_lo;

  logic [14:0]                t_prod_hi;
  logic [14:0]                t_prod_lo;
  logic [sfp7_pkg::BCD_W-1:0] t_hi;
  logic [sfp7_pkg::BCD_W-1:0] t_lo;
  logic [sfp7_pkg::REM_W-1:0] o_hi;
  logic [sfp7_pkg::REM_W-1:0] o_lo;
  logic [sfp7_pkg::BCD_W-1:0] d5;

  // hundreds and remainder below one hundred
  assign p_hi   = 16'(split.hi) * 16'(sfp7_pkg::RECIP_100);
  assign p_lo   = 16'(split.lo) * 16'(sfp7_pkg::RECIP_100);
  assign hh     = p_hi[sfp7_pkg::H_SHIFT +: sfp7_pkg::BCD_W];
  assign hl     = p_lo[sfp7_pkg::H_SHIFT +: sfp7_pkg::BCD_W];
  assign rem_hi = split.hi - sfp7_pkg::HI_W'(hh) * sfp7_pkg::HI_W'(100);
  assign rem_lo = sfp7_pkg::HI_W'(split.lo) - sfp7_pkg::HI_W'(hl) * sfp7_pkg::HI_W'(100);

  // tens and ones
  assign t_prod_hi = 15'(r_hi) * 15'(sfp7_pkg::RECIP_10);
  assign t_prod_lo = 15'(r_lo) * 15'(sfp7_pkg::RECIP_10);
  assign t_hi      = t_prod_hi[sfp7_pkg::T_SHIFT +: sfp7_pkg::BCD_W];
  assign t_lo      = t_prod_lo[sfp7_pkg::T_SHIFT +: sfp7_pkg::BCD_W];
  assign o_hi      = r_hi - sfp7_pkg::REM_W'(t_hi) * sfp7_pkg::REM_W'(10);
  assign o_lo      = r_lo - sfp7_pkg::REM_W'(t_lo) * sfp7_pkg::REM_W'(10);

  // magnitude past six digits wraps the top digit
  assign d5 = (h_hi == sfp7_pkg::BCD_W'(10)) ? '0 : h_hi;

  always_ff @(posedge clk) begin
    if (en) begin
      op4            <= split.op;
      neg4           <= split.neg;
      h_hi           <= hh;
      h_lo           <= hl;
      r_hi           <= rem_hi[sfp7_pkg::REM_W-1:0];
      r_lo           <= rem_lo[sfp7_pkg::REM_W-1:0];
      digits.op      <= op4;
      digits.neg     <= neg4;
      digits.dig[5]  <= d5;
      digits.dig[4]  <= t_hi;
      digits.dig[3]  <= o_hi[sfp7_pkg::BCD_W-1:0];
      digits.dig[2]  <= h_lo;
      digits.dig[1]  <= t_lo;
      digits.dig[0]  <= o_lo[sfp7_pkg::BCD_W-1:0];
    end
  end

endmodule

// ===== hdl/sfp7_encode.sv =====
// ----------------------------------------------------------------------------
// sfp7_encode
// segment patterns, leading zero blanking, minus sign and error pattern,
// into the result register
// ----------------------------------------------------------------------------
module sfp7_encode (
  input  logic                                         clk,
  input  logic                                         en,
  input  sfp7_pkg::digits_t                            digits,
  output logic [sfp7_pkg::DIGITS*sfp7_pkg::SEG_W-1:0]  seg
);

  logic [2:0]                                        top;
  logic [sfp7_pkg::DIGITS-1:0][sfp7_pkg::SEG_W-1:0]  num;
  logic [sfp7_pkg::DIGITS-1:0][sfp7_pkg::SEG_W-1:0]  seg_next;

  always_comb begin
    priority if (digits.dig[5] != '0) begin
      top = 3'd5;
    end else if (digits.dig[4] != '0) begin
      top = 3'd4;
    end else if (digits.dig[3] != '0) begin
      top = 3'd3;
    end else if (digits.dig[2] != '0) begin
      top = 3'd2;
    end else begin
      top = 3'd1;
    end
  end

  always_comb begin
    for (int k = 0; k < sfp7_pkg::DIGITS; k++) begin
      if (3'(k) <= top) begin
        num[k] = sfp7_pkg::seg_digit(digits.dig[k]);
      end else if (digits.neg && (3'(k) == top + 3'd1)) begin
        num[k] = sfp7_pkg::SEG_MINUS;
      end else begin
        num[k] = sfp7_pkg::SEG_BLANK;
      end
    end
    num[1] = num[1] & sfp7_pkg::SEG_DP_MASK;
  end

  always_comb begin
    unique case (digits.op)
      sfp7_pkg::OP_ERROR: begin
        seg_next[0] = sfp7_pkg::ERR_SEG0;
        seg_next[1] = sfp7_pkg::ERR_SEG1;
        seg_next[2] = sfp7_pkg::ERR_SEG2;
        seg_next[3] = sfp7_pkg::ERR_SEG3;
        seg_next[4] = sfp7_pkg::ERR_SEG4;
        seg_next[5] = sfp7_pkg::ERR_SEG5;
      end
      default: begin
        seg_next = num;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      seg <= seg_next;
    end
  end

endmodule

// ===== hdl/signed_fixed_point_to_seven_segment_core.sv =====
// ----------------------------------------------------------------------------
// signed_fixed_point_to_seven_segment_core
// Converts a signed count of tenths into six active-low seven-segment digit
// patterns (bit 7 is the decimal point, lit on digit 1), or the fixed "Error"
// pattern. One transfer is taken every cycle; the six-stage pipeline (input
// register, magnitude and quotient register, thousands split register, two
// digit stages, result register) advances as a whole and stalls only while a
// result waits on m_tready.
// ----------------------------------------------------------------------------
module signed_fixed_point_to_seven_segment_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // value[20:0], zero fill
  input  logic        s_tuser,   // operation
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata    // digit5 in [47:40] down to digit0 in [7:0]
);

  localparam int STAGES = 6;

  logic                    en;
  logic [STAGES-1:0]       vld;
  sfp7_pkg::split_t        split;
  sfp7_pkg::digits_t       digits;

  assign en       = !vld[STAGES-1] || m_tready;
  assign s_tready = en;
  assign m_tvalid = vld[STAGES-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[STAGES-2:0], s_tvalid};
    end
  end

  sfp7_split u_split (
    .clk   (clk),
    .en    (en),
    .op    (s_tuser),
    .value (s_tdata[sfp7_pkg::VALUE_W-1:0]),
    .split (split)
  );

  sfp7_digits u_digits (
    .clk    (clk),
    .en     (en),
    .split  (split),
    .digits (digits)
  );

  sfp7_encode u_encode (
    .clk    (clk),
    .en     (en),
    .digits (digits),
    .seg    (m_tdata)
  );

  // decimal point lit on digit 1 unless the error pattern is shown
  a_dp_lit: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[15] == 1'b0 || m_tdata[15:8] == sfp7_pkg::ERR_SEG1))
    else $error("decimal point missing on digit 1");

  // digit 0 is never blanked
  a_digit0_shown: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[7:0] != sfp7_pkg::SEG_BLANK)
    else $error("digit 0 blanked");

  // at most one minus sign
  a_one_minus: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> $countones({m_tdata[47:40] == sfp7_pkg::SEG_MINUS,
                             m_tdata[39:32] == sfp7_pkg::SEG_MINUS,
                             m_tdata[31:24] == sfp7_pkg::SEG_MINUS,
                             m_tdata[23:16] == sfp7_pkg::SEG_MINUS}) <= 1)
    else $error("more than one minus sign");

  // a taken result with a bubble behind it empties the output
  a_drain: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tready && !vld[STAGES-2]) |=> !m_tvalid)
    else $error("result repeated");

endmodule
